// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the tokenizer modules; NO_ASSERTIONS strips them
// ----------------------------------------------------------------------------

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define JST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies outcome in the next
`define JST_ASSERT_NEXT(label, clk, rst_n, cond, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) \
        else $error(msg);

`else

`define JST_ASSERT(label, clk, rst_n, prop, msg)
`define JST_ASSERT_NEXT(label, clk, rst_n, cond, outcome, msg)

`endif

`endif

// ===== src/jst_pkg.sv =====
// ----------------------------------------------------------------------------
// jst_pkg
// Shared constants and types of the JSON stream tokenizer
// ----------------------------------------------------------------------------

package jst_pkg;

    // sizing
    localparam int STACK_DEPTH = 16;
    localparam int DOC_LEN_MAX = 65535;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int POS_W       = $clog2(DOC_LEN_MAX + 1);
    localparam int OUT_W       = 16;

    // result queue, depth a power of two so pointers wrap by themselves
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // context stack entry codes
    typedef logic [1:0] t_ctx;
    localparam t_ctx CTX_NONE   = 2'd0;
    localparam t_ctx CTX_OBJECT = 2'd1;
    localparam t_ctx CTX_ARRAY  = 2'd2;
    localparam t_ctx CTX_PAIR   = 2'd3;

    typedef enum logic [3:0] {
        TOK_OBJ_OPEN  = 4'd0,
        TOK_OBJ_CLOSE = 4'd1,
        TOK_ARR_OPEN  = 4'd2,
        TOK_ARR_CLOSE = 4'd3,
        TOK_COMMA     = 4'd4,
        TOK_STRING    = 4'd5,
        TOK_NAME      = 4'd6,
        TOK_NUMBER    = 4'd7,
        TOK_NULL      = 4'd8,
        TOK_TRUE      = 4'd9,
        TOK_FALSE     = 4'd10,
        TOK_ERROR     = 4'd11,
        TOK_END       = 4'd12
    } t_token;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_BAD_OBJECT  = 3'd1,
        ERR_BAD_OBJ_END = 3'd2,
        ERR_BAD_ARR_END = 3'd3,
        ERR_SYNTAX      = 3'd4,
        ERR_BAD_STRING  = 3'd5,
        ERR_BAD_ARRAY   = 3'd6,
        ERR_OVERFLOW    = 3'd7
    } t_err;

    typedef enum logic [3:0] {
        VK_NONE   = 4'd0,
        VK_COMMA  = 4'd1,
        VK_NAME   = 4'd2,
        VK_STRING = 4'd3,
        VK_NUMBER = 4'd4,
        VK_NULL   = 4'd5,
        VK_TRUE   = 4'd6,
        VK_FALSE  = 4'd7,
        VK_CLOSED = 4'd8
    } t_value_kind;

    typedef enum logic [2:0] {
        SCAN_IDLE   = 3'd0,
        SCAN_STRING = 3'd1,
        SCAN_NAME   = 3'd2,
        SCAN_NUMBER = 3'd3,
        SCAN_NULL   = 3'd4,
        SCAN_TRUE   = 3'd5,
        SCAN_FALSE  = 3'd6
    } t_scan_mode;

    // per-cell load select in the stack chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_UP,
        CELL_FROM_DOWN
    } t_cell_op;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_SET_TOP
    } t_stack_op;

    typedef struct packed {
        t_stack_op op;
        t_ctx      code;
    } t_stack_ctl;

    typedef struct packed {
        t_token           token_kind;
        logic [OUT_W-1:0] value_start;
        logic [OUT_W-1:0] value_len;
        t_err             error_code;
        logic             last_of_run;
    } t_result;

endpackage

// ===== src/jst_if.sv =====
// ----------------------------------------------------------------------------
// jst_if
// Valid/ready stream channels for document bytes and tokens
// ----------------------------------------------------------------------------

// document byte channel
interface jst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       start_of_document;

    modport source (output valid, in_byte, end_of_input, start_of_document, input ready);
    modport sink (input valid, in_byte, end_of_input, start_of_document, output ready);
endinterface

// token channel
interface jst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] value_start;
    logic [15:0] value_len;
    logic [2:0]  error_code;
    logic        last_of_run;

    modport source (output valid, token_kind, value_start, value_len, error_code,
                    last_of_run, input ready);
    modport sink (input valid, token_kind, value_start, value_len, error_code,
                  last_of_run, output ready);
endinterface

// ===== src/jst_stack_cell.sv =====
// ----------------------------------------------------------------------------
// jst_stack_cell
// One entry of the shifting context stack
// ----------------------------------------------------------------------------

module jst_stack_cell import jst_pkg::*; (
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_ctx     i_from_up,
    input  t_ctx     i_from_down,
    output t_ctx     o_value
);

    t_ctx r_value;
    t_ctx n_value;

    // pick the neighbor to load from
    always_comb begin
        case (i_op)
            CELL_FROM_UP:   n_value = i_from_up;
            CELL_FROM_DOWN: n_value = i_from_down;
            default:        n_value = r_value;
        endcase
    end

    // entry holds no reset, it is read only below the stack depth
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== src/jst_ctx_stack.sv =====
// ----------------------------------------------------------------------------
// jst_ctx_stack
// Context stack as a chain of cells, top of stack in the first cell
// ----------------------------------------------------------------------------

module jst_ctx_stack import jst_pkg::*; (
    input  logic       i_clk,
    input  t_stack_ctl i_ctl,
    output t_ctx       o_top
);

    t_ctx w_value [STACK_DEPTH];

    // push shifts down, pop shifts up, set-top reloads the first cell only
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_cell_op w_op;
        t_ctx     w_up;
        t_ctx     w_down;

        always_comb begin
            case (i_ctl.op)
                STK_PUSH:    w_op = CELL_FROM_UP;
                STK_POP:     w_op = CELL_FROM_DOWN;
                STK_SET_TOP: w_op = (g == 0) ? CELL_FROM_UP : CELL_HOLD;
                default:     w_op = CELL_HOLD;
            endcase
        end

        if (g == 0) begin : g_head
            assign w_up = i_ctl.code;
        end else begin : g_body
            assign w_up = w_value[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_down = CTX_NONE;
        end else begin : g_link
            assign w_down = w_value[g+1];
        end

        jst_stack_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_value     (w_value[g])
        );
    end

    assign o_top = w_value[0];

endmodule

// ===== src/jst_out_queue.sv =====
// ----------------------------------------------------------------------------
// jst_out_queue
// Small result queue taking up to two words per cycle while it has room, one out per cycle while the sink is ready
// ----------------------------------------------------------------------------

`include "assert_macros.svh"

module jst_out_queue import jst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_wr_count,
    input  t_result     i_wr0,
    input  t_result     i_wr1,
    output logic        o_space,
    jst_out_if.source   o_out
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_wr_ptr;
    logic [Q_PTR_W-1:0]   n_rd_ptr;
    logic [Q_CNT_W-1:0]   n_count;
    logic [Q_PTR_W-1:0]   w_wr_next;
    logic                 w_pop;
    t_result              w_head;

    assign w_pop     = o_out.valid && o_out.ready;
    assign w_wr_next = r_wr_ptr + Q_PTR_W'(1);
    assign o_space   = r_count <= Q_CNT_W'(Q_DEPTH - 2);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_wr_count);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(w_pop);
        n_count  = r_count + Q_CNT_W'(i_wr_count) - Q_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, two write slots
    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[w_wr_next] <= i_wr1;
        end
    end

    // head word to the port
    assign w_head            = r_mem[r_rd_ptr];
    assign o_out.valid       = r_count != '0;
    assign o_out.token_kind  = w_head.token_kind;
    assign o_out.value_start = w_head.value_start;
    assign o_out.value_len   = w_head.value_len;
    assign o_out.error_code  = w_head.error_code;
    assign o_out.last_of_run = w_head.last_of_run;

    `JST_ASSERT(a_q_bound, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH), "result queue overfilled")
    `JST_ASSERT(a_q_space, i_clk, i_rst_n, (i_wr_count != 2'd0) |-> o_space, "write without room")
    `JST_ASSERT_NEXT(a_q_drain, i_clk, i_rst_n, w_pop && (i_wr_count == 2'd0), r_count == $past(r_count) - Q_CNT_W'(1), "pop did not drain")

endmodule

// ===== src/json_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// json_stream_tokenizer: JSON byte stream to tokens with start and length
// Throughput: one byte word per cycle while the four-entry result queue has room;
// results leave the queue one per cycle while the sink is ready.
// Reset: synchronous active low; start_of_document clears parser state in-band.
// ----------------------------------------------------------------------------

`include "assert_macros.svh"

module json_stream_tokenizer import jst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jst_in_if.sink    i_in,
    jst_out_if.source o_out
);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [POS_W-1:0]   POS_MAX    = POS_W'(DOC_LEN_MAX);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    function automatic logic is_ws(logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    endfunction

    // expected spelling of each literal
    function automatic logic [7:0] lit_char(t_scan_mode m, logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (m)
            SCAN_NULL: begin
                case (idx)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
            SCAN_TRUE: begin
                case (idx)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            SCAN_FALSE: begin
                case (idx)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(t_scan_mode m);
        return (m == SCAN_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic t_result mk_result(t_token k, logic [OUT_W-1:0] st,
                                          logic [OUT_W-1:0] ln, t_err e);
        t_result r;
        r.token_kind  = k;
        r.value_start = st;
        r.value_len   = ln;
        r.error_code  = e;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // parser state
    logic [DEPTH_W-1:0] r_depth;
    t_value_kind        r_last;
    logic [POS_W-1:0]   r_pos;
    t_scan_mode         r_mode;
    logic               r_escape;
    logic [2:0]         r_lit_idx;
    logic               r_lit_ok;
    logic [POS_W-1:0]   r_pstart;
    logic               r_err;

    logic [DEPTH_W-1:0] n_depth;
    t_value_kind        n_last;
    logic [POS_W-1:0]   n_pos;
    t_scan_mode         n_mode;
    logic               n_escape;
    logic [2:0]         n_lit_idx;
    logic               n_lit_ok;
    logic [POS_W-1:0]   n_pstart;
    logic               n_err;

    // state as seen by the current word, after an in-band restart
    logic [DEPTH_W-1:0] cur_depth;
    t_value_kind        cur_last;
    logic [POS_W-1:0]   cur_pos;
    t_scan_mode         cur_mode;
    logic               cur_escape;
    logic [2:0]         cur_lit_idx;
    logic               cur_lit_ok;
    logic [POS_W-1:0]   cur_pstart;
    logic               cur_err;

    logic               w_sod;
    logic               w_in_acc;
    logic               w_space;
    t_ctx               w_stack_top;
    t_ctx               w_top;
    logic [POS_W-1:0]   w_span;
    logic [7:0]         w_byte;
    logic               w_eod;
    logic               w_digit;

    t_stack_ctl         w_ctl;
    t_stack_ctl         w_ctl_gated;
    t_result            w_res_a;
    t_result            w_res_b;
    logic               w_a_v;
    logic               w_b_v;
    logic [1:0]         w_wr_count;
    t_result            w_wr0;
    t_result            w_wr1;

    logic               w_run_idle;
    logic               w_do_finish;
    logic               w_may_start;
    logic               w_value_ctx;
    logic               w_fail;
    t_err               w_fail_code;

    assign w_sod    = i_in.start_of_document;
    assign w_in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = w_space;

    assign cur_depth   = w_sod ? '0 : r_depth;
    assign cur_last    = w_sod ? VK_NONE : r_last;
    assign cur_pos     = w_sod ? '0 : r_pos;
    assign cur_mode    = w_sod ? SCAN_IDLE : r_mode;
    assign cur_escape  = w_sod ? 1'b0 : r_escape;
    assign cur_lit_idx = w_sod ? 3'd0 : r_lit_idx;
    assign cur_lit_ok  = w_sod ? 1'b1 : r_lit_ok;
    assign cur_pstart  = w_sod ? '0 : r_pstart;
    assign cur_err     = w_sod ? 1'b0 : r_err;

    assign w_top   = (cur_depth == '0) ? CTX_NONE : w_stack_top;
    assign w_span  = (cur_pos > cur_pstart) ? (cur_pos - cur_pstart) : '0;
    assign w_byte  = i_in.in_byte;
    assign w_eod   = i_in.end_of_input || (w_byte == 8'h00);
    assign w_digit = (w_byte >= CH_ZERO) && (w_byte <= CH_NINE);

    // next state and results of one word
    always_comb begin
        n_depth     = cur_depth;
        n_last      = cur_last;
        n_pos       = cur_pos;
        n_mode      = cur_mode;
        n_escape    = cur_escape;
        n_lit_idx   = cur_lit_idx;
        n_lit_ok    = cur_lit_ok;
        n_pstart    = cur_pstart;
        n_err       = cur_err;
        w_ctl.op    = STK_HOLD;
        w_ctl.code  = CTX_NONE;
        w_a_v       = 1'b0;
        w_b_v       = 1'b0;
        w_res_a     = mk_result(TOK_END, '0, '0, ERR_NONE);
        w_res_b     = mk_result(TOK_END, '0, '0, ERR_NONE);
        w_run_idle  = 1'b0;
        w_do_finish = 1'b0;
        w_may_start = 1'b0;
        w_value_ctx = 1'b0;
        w_fail      = 1'b0;
        w_fail_code = ERR_SYNTAX;

        // scan step on the byte
        if (!cur_err) begin
            if (w_eod) begin
                if (cur_mode == SCAN_STRING || cur_mode == SCAN_NAME) begin
                    w_a_v    = 1'b1;
                    w_res_a  = mk_result(TOK_ERROR, '0, '0, ERR_SYNTAX);
                    n_err    = 1'b1;
                    n_mode   = SCAN_IDLE;
                    n_escape = 1'b0;
                end else if (cur_mode != SCAN_IDLE) begin
                    w_do_finish = 1'b1;
                end
            end else begin
                if (cur_pos < POS_MAX) begin
                    n_pos = cur_pos + POS_W'(1);
                end
                case (cur_mode)
                    SCAN_STRING, SCAN_NAME: begin
                        if (cur_escape) begin
                            n_escape = 1'b0;
                        end else if (w_byte == CH_BSLASH) begin
                            n_escape = 1'b1;
                        end else if (w_byte == CH_QUOTE) begin
                            w_a_v   = 1'b1;
                            w_res_a = mk_result(
                                (cur_mode == SCAN_NAME) ? TOK_NAME : TOK_STRING,
                                OUT_W'(cur_pstart), OUT_W'(w_span), ERR_NONE);
                            n_last  = (cur_mode == SCAN_NAME) ? VK_NAME : VK_STRING;
                            n_mode  = SCAN_IDLE;
                        end
                    end
                    SCAN_NUMBER: begin
                        if (!(w_digit || w_byte == CH_DOT)) begin
                            w_do_finish = 1'b1;
                            w_run_idle  = 1'b1;
                        end
                    end
                    SCAN_NULL, SCAN_TRUE, SCAN_FALSE: begin
                        if (is_ws(w_byte) || w_byte == CH_COMMA || w_byte == CH_RBRACK
                                || w_byte == CH_RBRACE) begin
                            w_do_finish = 1'b1;
                            w_run_idle  = 1'b1;
                        end else begin
                            if (cur_lit_idx >= lit_len(cur_mode)
                                    || w_byte != lit_char(cur_mode, cur_lit_idx)) begin
                                n_lit_ok = 1'b0;
                            end
                            if (cur_lit_idx < 3'd7) begin
                                n_lit_idx = cur_lit_idx + 3'd1;
                            end
                        end
                    end
                    default: w_run_idle = 1'b1;
                endcase
            end
        end

        // close a pending number or literal
        if (w_do_finish) begin
            w_a_v  = 1'b1;
            n_mode = SCAN_IDLE;
            if (cur_mode == SCAN_NUMBER) begin
                w_res_a = mk_result(TOK_NUMBER, OUT_W'(cur_pstart), OUT_W'(w_span), ERR_NONE);
                n_last  = VK_NUMBER;
            end else if (cur_lit_ok && cur_lit_idx == lit_len(cur_mode)) begin
                case (cur_mode)
                    SCAN_NULL: begin
                        w_res_a = mk_result(TOK_NULL, OUT_W'(cur_pstart), OUT_W'(w_span),
                                            ERR_NONE);
                        n_last  = VK_NULL;
                    end
                    SCAN_TRUE: begin
                        w_res_a = mk_result(TOK_TRUE, OUT_W'(cur_pstart), OUT_W'(w_span),
                                            ERR_NONE);
                        n_last  = VK_TRUE;
                    end
                    default: begin
                        w_res_a = mk_result(TOK_FALSE, OUT_W'(cur_pstart), OUT_W'(w_span),
                                            ERR_NONE);
                        n_last  = VK_FALSE;
                    end
                endcase
            end else begin
                w_res_a  = mk_result(TOK_ERROR, '0, '0, ERR_SYNTAX);
                n_err    = 1'b1;
                n_escape = 1'b0;
            end
        end

        // structural byte or start of a value
        if (w_run_idle && !n_err && !is_ws(w_byte)) begin
            w_may_start = (n_last == VK_NONE) || (n_last == VK_COMMA);
            w_value_ctx = (w_top != CTX_OBJECT) && w_may_start;
            case (w_byte)
                CH_LBRACE, CH_LBRACK: begin
                    if (!w_value_ctx) begin
                        w_fail      = 1'b1;
                        w_fail_code = (w_byte == CH_LBRACE) ? ERR_BAD_OBJECT : ERR_BAD_ARRAY;
                    end else if (cur_depth >= DEPTH_FULL) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_OVERFLOW;
                    end else begin
                        w_ctl.op   = STK_PUSH;
                        w_ctl.code = (w_byte == CH_LBRACE) ? CTX_OBJECT : CTX_ARRAY;
                        n_depth    = cur_depth + DEPTH_W'(1);
                        n_last     = VK_NONE;
                        w_b_v      = 1'b1;
                        w_res_b    = mk_result(
                            (w_byte == CH_LBRACE) ? TOK_OBJ_OPEN : TOK_ARR_OPEN,
                            '0, '0, ERR_NONE);
                    end
                end
                CH_RBRACE: begin
                    if ((w_top == CTX_PAIR && n_last != VK_COMMA && n_last != VK_NONE)
                            || (w_top == CTX_OBJECT && n_last == VK_NONE)) begin
                        w_ctl.op = STK_POP;
                        n_depth  = cur_depth - DEPTH_W'(1);
                        n_last   = VK_CLOSED;
                        w_b_v    = 1'b1;
                        w_res_b  = mk_result(TOK_OBJ_CLOSE, '0, '0, ERR_NONE);
                    end else begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_BAD_OBJ_END;
                    end
                end
                CH_RBRACK: begin
                    if (w_top == CTX_ARRAY && n_last != VK_COMMA) begin
                        w_ctl.op = STK_POP;
                        n_depth  = cur_depth - DEPTH_W'(1);
                        n_last   = VK_CLOSED;
                        w_b_v    = 1'b1;
                        w_res_b  = mk_result(TOK_ARR_CLOSE, '0, '0, ERR_NONE);
                    end else begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_BAD_ARR_END;
                    end
                end
                CH_COLON: begin
                    if (w_top == CTX_OBJECT && n_last == VK_NAME) begin
                        w_ctl.op   = STK_SET_TOP;
                        w_ctl.code = CTX_PAIR;
                        n_last     = VK_NONE;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                CH_COMMA: begin
                    if ((w_top == CTX_PAIR && n_last != VK_NONE)
                            || (w_top == CTX_ARRAY && n_last != VK_NONE
                                && n_last != VK_COMMA)) begin
                        if (w_top == CTX_PAIR) begin
                            w_ctl.op   = STK_SET_TOP;
                            w_ctl.code = CTX_OBJECT;
                        end
                        n_last  = VK_COMMA;
                        w_b_v   = 1'b1;
                        w_res_b = mk_result(TOK_COMMA, '0, '0, ERR_NONE);
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                CH_QUOTE: begin
                    if (!w_may_start) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_BAD_STRING;
                    end else begin
                        n_mode   = (w_top == CTX_OBJECT) ? SCAN_NAME : SCAN_STRING;
                        n_escape = 1'b0;
                        n_pstart = (cur_pos < POS_MAX) ? cur_pos + POS_W'(1) : POS_MAX;
                    end
                end
                default: begin
                    if (w_top == CTX_OBJECT || !w_may_start) begin
                        w_fail = 1'b1;
                    end else begin
                        n_pstart  = cur_pos;
                        n_lit_idx = 3'd1;
                        n_lit_ok  = 1'b1;
                        if (w_byte == CH_MINUS || w_digit) begin
                            n_mode = SCAN_NUMBER;
                        end else if (w_byte == CH_LOW_N) begin
                            n_mode = SCAN_NULL;
                        end else if (w_byte == CH_LOW_T) begin
                            n_mode = SCAN_TRUE;
                        end else if (w_byte == CH_LOW_F) begin
                            n_mode = SCAN_FALSE;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                end
            endcase
        end

        // error from the structural step
        if (w_fail) begin
            w_b_v    = 1'b1;
            w_res_b  = mk_result(TOK_ERROR, '0, '0, w_fail_code);
            n_err    = 1'b1;
            n_mode   = SCAN_IDLE;
            n_escape = 1'b0;
        end

        // end of document check
        if (w_eod && !cur_err && !n_err) begin
            w_b_v = 1'b1;
            if (n_last == VK_NONE || cur_depth != '0) begin
                w_res_b  = mk_result(TOK_ERROR, '0, '0, ERR_SYNTAX);
                n_err    = 1'b1;
                n_mode   = SCAN_IDLE;
                n_escape = 1'b0;
            end else begin
                w_res_b = mk_result(TOK_END, '0, '0, ERR_NONE);
            end
        end
    end

    // pack results in order, mark the final one
    always_comb begin
        w_wr0 = w_a_v ? w_res_a : w_res_b;
        w_wr1 = w_res_b;
        w_wr0.last_of_run = !(w_a_v && w_b_v);
        w_wr1.last_of_run = 1'b1;
        w_wr_count = w_in_acc ? (2'(w_a_v) + 2'(w_b_v)) : 2'd0;
        w_ctl_gated = w_ctl;
        if (!w_in_acc) begin
            w_ctl_gated.op = STK_HOLD;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_last    <= VK_NONE;
            r_pos     <= '0;
            r_mode    <= SCAN_IDLE;
            r_escape  <= 1'b0;
            r_lit_idx <= 3'd0;
            r_lit_ok  <= 1'b1;
            r_pstart  <= '0;
            r_err     <= 1'b0;
        end else if (w_in_acc) begin
            r_depth   <= n_depth;
            r_last    <= n_last;
            r_pos     <= n_pos;
            r_mode    <= n_mode;
            r_escape  <= n_escape;
            r_lit_idx <= n_lit_idx;
            r_lit_ok  <= n_lit_ok;
            r_pstart  <= n_pstart;
            r_err     <= n_err;
        end
    end

    jst_ctx_stack u_stack (
        .i_clk (i_clk),
        .i_ctl (w_ctl_gated),
        .o_top (w_stack_top)
    );

    jst_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (w_wr_count),
        .i_wr0      (w_wr0),
        .i_wr1      (w_wr1),
        .o_space    (w_space),
        .o_out      (o_out)
    );

    `JST_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= DEPTH_FULL, "stack depth beyond capacity")
    `JST_ASSERT(a_push_room, i_clk, i_rst_n, (w_ctl_gated.op == STK_PUSH) |-> (cur_depth < DEPTH_FULL), "push at full stack")
    `JST_ASSERT(a_err_silent, i_clk, i_rst_n, (w_in_acc && cur_err) |-> (w_wr_count == 2'd0), "result after latched error")
    `JST_ASSERT(a_escape_mode, i_clk, i_rst_n, r_escape |-> (r_mode == SCAN_STRING || r_mode == SCAN_NAME), "escape outside string")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON stream tokenizer: documents are fed byte by
// byte over the input channel in random bursts, a software tokenizer predicts
// every token, and a stalling token sink compares each token field by field
// ----------------------------------------------------------------------------

module tb_top;
    import jst_pkg::*;

    // bench timing
    localparam int unsigned RUN_LIMIT   = 20_000_000;
    localparam int unsigned DRAIN_TICKS = 8;

    // document bytes with special meaning
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       sod;
    } t_doc_word;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_ALTERNATE,
        RX_MOSTLY,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jst_in_if  in_if ();
    jst_out_if out_if ();

    json_stream_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and expectation stores
    t_doc_word   byte_feed_q[$];
    t_result     token_expect_q[$];
    t_result     step_toks[$];
    logic [7:0]  doc_buf[$];

    // statistics
    int unsigned mismatch_count;
    int unsigned words_taken;
    int unsigned tokens_seen;
    int unsigned error_tokens;
    int unsigned end_tokens;
    int unsigned docs_built;

    // predicted parser state
    t_ctx        ctx_stk [STACK_DEPTH];
    int unsigned stk_lvl;
    t_value_kind prev_kind;
    int unsigned doc_pos;
    t_scan_mode  scan;
    bit          esc_armed;
    int unsigned lit_pos;
    bit          lit_good;
    int unsigned text_start;
    bit          err_stuck;

    // ------------------------------------------------------------------
    // token prediction
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        foreach (ctx_stk[i]) ctx_stk[i] = CTX_NONE;
        stk_lvl    = 0;
        prev_kind  = VK_NONE;
        doc_pos    = 0;
        scan       = SCAN_IDLE;
        esc_armed  = 1'b0;
        lit_pos    = 0;
        lit_good   = 1'b1;
        text_start = 0;
        err_stuck  = 1'b0;
    endfunction

    function automatic int unsigned text_span(int unsigned a, int unsigned b);
        return (b > a) ? b - a : 0;
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic string lit_spelling(t_scan_mode m);
        case (m)
            SCAN_NULL: return "null";
            SCAN_TRUE: return "true";
            default:   return "false";
        endcase
    endfunction

    // at most two tokens per input word
    function automatic void push_tok(t_token k, int unsigned st, int unsigned ln, t_err e);
        t_result r;
        if (step_toks.size() >= 2) return;
        r.token_kind  = k;
        r.value_start = OUT_W'(st);
        r.value_len   = OUT_W'(ln);
        r.error_code  = e;
        r.last_of_run = 1'b0;
        step_toks.push_back(r);
    endfunction

    function automatic void raise_error(t_err e);
        push_tok(TOK_ERROR, 0, 0, e);
        err_stuck = 1'b1;
        scan      = SCAN_IDLE;
        esc_armed = 1'b0;
    endfunction

    function automatic t_ctx top_ctx();
        if (stk_lvl == 0 || stk_lvl > STACK_DEPTH) return CTX_NONE;
        return ctx_stk[stk_lvl-1];
    endfunction

    // close out a number or literal that ends at pos
    function automatic void finish_value(int unsigned pos);
        int unsigned ln;
        string       spelling;
        ln = text_span(text_start, pos);
        if (scan == SCAN_NUMBER) begin
            push_tok(TOK_NUMBER, text_start, ln, ERR_NONE);
            prev_kind = VK_NUMBER;
        end else if (scan == SCAN_NULL || scan == SCAN_TRUE || scan == SCAN_FALSE) begin
            spelling = lit_spelling(scan);
            if (!lit_good || lit_pos != spelling.len()) begin
                raise_error(ERR_SYNTAX);
                return;
            end
            case (scan)
                SCAN_NULL: begin
                    push_tok(TOK_NULL, text_start, ln, ERR_NONE);
                    prev_kind = VK_NULL;
                end
                SCAN_TRUE: begin
                    push_tok(TOK_TRUE, text_start, ln, ERR_NONE);
                    prev_kind = VK_TRUE;
                end
                default: begin
                    push_tok(TOK_FALSE, text_start, ln, ERR_NONE);
                    prev_kind = VK_FALSE;
                end
            endcase
        end
        scan = SCAN_IDLE;
    endfunction

    function automatic void open_ctx(t_ctx c, t_token k);
        if (stk_lvl >= STACK_DEPTH) begin
            raise_error(ERR_OVERFLOW);
            return;
        end
        ctx_stk[stk_lvl] = c;
        stk_lvl++;
        prev_kind = VK_NONE;
        push_tok(k, 0, 0, ERR_NONE);
    endfunction

    function automatic void close_ctx(t_token k);
        if (stk_lvl > 0) stk_lvl--;
        prev_kind = VK_CLOSED;
        push_tok(k, 0, 0, ERR_NONE);
    endfunction

    // byte seen between tokens
    function automatic void idle_byte(logic [7:0] b, int unsigned pos);
        t_ctx s;
        bit   may_start;
        bit   value_ctx;
        s         = top_ctx();
        may_start = prev_kind == VK_NONE || prev_kind == VK_COMMA;
        value_ctx = s != CTX_OBJECT && may_start;
        if (is_blank(b)) return;
        case (b)
            CH_LBRACE: begin
                if (value_ctx) open_ctx(CTX_OBJECT, TOK_OBJ_OPEN);
                else raise_error(ERR_BAD_OBJECT);
            end
            CH_LBRACK: begin
                if (value_ctx) open_ctx(CTX_ARRAY, TOK_ARR_OPEN);
                else raise_error(ERR_BAD_ARRAY);
            end
            CH_RBRACE: begin
                if ((s == CTX_PAIR && prev_kind != VK_COMMA && prev_kind != VK_NONE) ||
                    (s == CTX_OBJECT && prev_kind == VK_NONE))
                    close_ctx(TOK_OBJ_CLOSE);
                else
                    raise_error(ERR_BAD_OBJ_END);
            end
            CH_RBRACK: begin
                if (s == CTX_ARRAY && prev_kind != VK_COMMA) close_ctx(TOK_ARR_CLOSE);
                else raise_error(ERR_BAD_ARR_END);
            end
            CH_COLON: begin
                if (s == CTX_OBJECT && prev_kind == VK_NAME) begin
                    ctx_stk[stk_lvl-1] = CTX_PAIR;
                    prev_kind = VK_NONE;
                end else begin
                    raise_error(ERR_SYNTAX);
                end
            end
            CH_COMMA: begin
                if ((s == CTX_PAIR && prev_kind != VK_NONE) ||
                    (s == CTX_ARRAY && prev_kind != VK_NONE && prev_kind != VK_COMMA)) begin
                    if (s == CTX_PAIR) ctx_stk[stk_lvl-1] = CTX_OBJECT;
                    prev_kind = VK_COMMA;
                    push_tok(TOK_COMMA, 0, 0, ERR_NONE);
                end else begin
                    raise_error(ERR_SYNTAX);
                end
            end
            CH_QUOTE: begin
                if (!may_start) begin
                    raise_error(ERR_BAD_STRING);
                end else begin
                    scan       = (s == CTX_OBJECT) ? SCAN_NAME : SCAN_STRING;
                    esc_armed  = 1'b0;
                    text_start = (pos < DOC_LEN_MAX) ? pos + 1 : DOC_LEN_MAX;
                end
            end
            default: begin
                if (s == CTX_OBJECT || !may_start) begin
                    raise_error(ERR_SYNTAX);
                end else begin
                    text_start = pos;
                    lit_pos    = 1;
                    lit_good   = 1'b1;
                    if (b == CH_MINUS || is_digit(b)) scan = SCAN_NUMBER;
                    else if (b == CH_LC_N) scan = SCAN_NULL;
                    else if (b == CH_LC_T) scan = SCAN_TRUE;
                    else if (b == CH_LC_F) scan = SCAN_FALSE;
                    else raise_error(ERR_SYNTAX);
                end
            end
        endcase
    endfunction

    // one accepted word: update the state and queue the tokens it causes
    function automatic void tokenize_byte(t_doc_word w);
        int unsigned here;
        string       spelling;
        step_toks.delete();
        if (w.sod) clear_parser();
        if (err_stuck) return;
        here = doc_pos;
        if (w.eoi || w.data == CH_NUL) begin
            // end of document: finish what is open, then end or error
            if (scan == SCAN_STRING || scan == SCAN_NAME) raise_error(ERR_SYNTAX);
            else if (scan != SCAN_IDLE) finish_value(here);
            if (!err_stuck) begin
                if (prev_kind == VK_NONE || stk_lvl > 0) raise_error(ERR_SYNTAX);
                else push_tok(TOK_END, 0, 0, ERR_NONE);
            end
        end else begin
            if (doc_pos < DOC_LEN_MAX) doc_pos++;
            case (scan)
                SCAN_STRING, SCAN_NAME: begin
                    if (esc_armed) begin
                        esc_armed = 1'b0;
                    end else if (w.data == CH_BSLASH) begin
                        esc_armed = 1'b1;
                    end else if (w.data == CH_QUOTE) begin
                        if (scan == SCAN_NAME) begin
                            push_tok(TOK_NAME, text_start, text_span(text_start, here), ERR_NONE);
                            prev_kind = VK_NAME;
                        end else begin
                            push_tok(TOK_STRING, text_start, text_span(text_start, here),
                                     ERR_NONE);
                            prev_kind = VK_STRING;
                        end
                        scan = SCAN_IDLE;
                    end
                end
                SCAN_NUMBER: begin
                    if (!is_digit(w.data) && w.data != CH_DOT) begin
                        finish_value(here);
                        if (!err_stuck) idle_byte(w.data, here);
                    end
                end
                SCAN_NULL, SCAN_TRUE, SCAN_FALSE: begin
                    if (is_blank(w.data) || w.data == CH_COMMA || w.data == CH_RBRACK ||
                        w.data == CH_RBRACE) begin
                        finish_value(here);
                        if (!err_stuck) idle_byte(w.data, here);
                    end else begin
                        spelling = lit_spelling(scan);
                        if (lit_pos >= spelling.len() || w.data != spelling[lit_pos])
                            lit_good = 1'b0;
                        if (lit_pos < 7) lit_pos++;
                    end
                end
                default: idle_byte(w.data, here);
            endcase
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1'b1;
        foreach (step_toks[i]) token_expect_q.push_back(step_toks[i]);
    endfunction

    // ------------------------------------------------------------------
    // document builders
    // ------------------------------------------------------------------

    function automatic void put_word(logic [7:0] b, logic eoi, logic sod);
        t_doc_word w;
        w.data = b;
        w.eoi  = eoi;
        w.sod  = sod;
        byte_feed_q.push_back(w);
    endfunction

    function automatic void add_text(string s);
        foreach (s[i]) doc_buf.push_back(s[i]);
    endfunction

    function automatic void add_ws();
        case ($urandom_range(0, 9))
            0: doc_buf.push_back(CH_SPACE);
            1: doc_buf.push_back(CH_TAB);
            2: doc_buf.push_back(CH_CR);
            3: doc_buf.push_back(CH_LF);
            4: add_text("  ");
            default: ;
        endcase
    endfunction

    function automatic void add_string();
        int unsigned n;
        logic [7:0]  c;
        doc_buf.push_back(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(0, 7))
                // escape: any nonzero byte after the backslash, a quote too
                0: begin
                    doc_buf.push_back(CH_BSLASH);
                    doc_buf.push_back(8'($urandom_range(1, 255)));
                end
                1: begin
                    c = 8'($urandom_range(1, 255));
                    if (c == CH_QUOTE || c == CH_BSLASH) c = CH_LC_A;
                    doc_buf.push_back(c);
                end
                default: doc_buf.push_back(8'(CH_LC_A + $urandom_range(0, 25)));
            endcase
        end
        doc_buf.push_back(CH_QUOTE);
    endfunction

    function automatic void add_number();
        if ($urandom_range(0, 2) == 0) doc_buf.push_back(CH_MINUS);
        repeat ($urandom_range(1, 4)) doc_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
            doc_buf.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) doc_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endfunction

    // literal, now and then cut short or with a stray letter
    function automatic void add_literal();
        string spelling;
        case ($urandom_range(0, 2))
            0:       spelling = "null";
            1:       spelling = "true";
            default: spelling = "false";
        endcase
        case ($urandom_range(0, 9))
            0: add_text(spelling.substr(0, spelling.len() - 2));
            1: begin
                add_text(spelling);
                doc_buf.push_back(8'(CH_LC_A + $urandom_range(0, 25)));
            end
            default: add_text(spelling);
        endcase
    endfunction

    function automatic void add_value(int unsigned lvl);
        int unsigned n;
        add_ws();
        case ((lvl >= 3) ? $urandom_range(0, 2) : $urandom_range(0, 4))
            0: add_number();
            1: add_string();
            2: add_literal();
            3: begin
                doc_buf.push_back(CH_LBRACK);
                n = $urandom_range(0, 3);
                for (int unsigned i = 0; i < n; i++) begin
                    if (i > 0) doc_buf.push_back(CH_COMMA);
                    add_value(lvl + 1);
                end
                add_ws();
                doc_buf.push_back(CH_RBRACK);
            end
            default: begin
                doc_buf.push_back(CH_LBRACE);
                n = $urandom_range(0, 3);
                for (int unsigned i = 0; i < n; i++) begin
                    if (i > 0) doc_buf.push_back(CH_COMMA);
                    add_ws();
                    add_string();
                    add_ws();
                    doc_buf.push_back(CH_COLON);
                    add_value(lvl + 1);
                end
                add_ws();
                doc_buf.push_back(CH_RBRACE);
            end
        endcase
        add_ws();
    endfunction

    // nesting around the stack limit, mixing arrays and pair values
    function automatic void add_nest();
        logic [7:0]  closers[$];
        int unsigned n;
        n = $urandom_range(12, 18);
        repeat (n) begin
            if ($urandom_range(0, 1) == 1) begin
                doc_buf.push_back(CH_LBRACK);
                closers.push_front(CH_RBRACK);
            end else begin
                add_text("{\"k\":");
                closers.push_front(CH_RBRACE);
            end
        end
        add_value(3);
        foreach (closers[i]) doc_buf.push_back(closers[i]);
    endfunction

    // move the built document to the feed, ending with an end word when with_end is set
    function automatic void emit_doc(bit with_sod, bit with_end);
        foreach (doc_buf[i]) put_word(doc_buf[i], 1'b0, with_sod && i == 0);
        if (with_end) begin
            if ($urandom_range(0, 3) == 0)
                put_word(CH_NUL, 1'b0, with_sod && doc_buf.size() == 0);
            else
                put_word(8'($urandom_range(0, 255)), 1'b1, with_sod && doc_buf.size() == 0);
        end
        doc_buf.delete();
        docs_built++;
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps
    // ------------------------------------------------------------------

    t_doc_word   cur_word;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin : feed
        logic nxt_valid;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            nxt_valid = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                tokenize_byte(cur_word);
                words_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_feed_q.size() > 0) begin
                    cur_word = byte_feed_q.pop_front();
                    in_if.in_byte           <= cur_word.data;
                    in_if.end_of_input      <= cur_word.eoi;
                    in_if.start_of_document <= cur_word.sod;
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
            in_if.valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // monitor: stalling sink and token compare
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("token %0d %s: got %0h, want %0h",
                                      tokens_seen, name, got, want));
    endtask

    t_rx_mode    rx_mode   = RX_OPEN;
    int unsigned rx_remain = 0;

    always @(posedge i_clk) begin : sink
        t_result want;
        logic    nxt_ready;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (token_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d", out_if.token_kind));
                end else begin
                    want = token_expect_q.pop_front();
                    check_field("token_kind", out_if.token_kind, want.token_kind);
                    check_field("value_start", out_if.value_start, want.value_start);
                    check_field("value_len", out_if.value_len, want.value_len);
                    check_field("error_code", out_if.error_code, want.error_code);
                    check_field("last_of_run", out_if.last_of_run, want.last_of_run);
                    if (want.token_kind == TOK_ERROR) error_tokens++;
                    if (want.token_kind == TOK_END) end_tokens++;
                end
                tokens_seen++;
            end
            // stall pattern is redrawn from the four modes each time its run counter runs out
            if (rx_remain == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                rx_remain = $urandom_range(16, 200);
            end else begin
                rx_remain--;
            end
            case (rx_mode)
                RX_OPEN:      nxt_ready = 1'b1;
                RX_ALTERNATE: nxt_ready = !out_if.ready;
                RX_MOSTLY:    nxt_ready = $urandom_range(0, 3) != 0;
                default:      nxt_ready = $urandom_range(0, 3) == 0;
            endcase
            out_if.ready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------

    initial begin : stimulus
        int unsigned goal;
        int unsigned cut;
        bit          sod_on;
        in_if.valid             = 1'b0;
        in_if.in_byte           = 8'h00;
        in_if.end_of_input      = 1'b0;
        in_if.start_of_document = 1'b0;
        out_if.ready            = 1'b0;
        i_rst_n                 = 1'b0;
        clear_parser();

        // directed: every token kind, a number and a literal closed by a delimiter
        add_text("{\"k\":-1.5}");
        emit_doc(1'b1, 1'b1);
        add_text("[true,false,\"s\",null]");
        emit_doc(1'b1, 1'b1);
        // comma right after an open bracket
        add_text("[,");
        emit_doc(1'b1, 1'b0);
        // escaped quote leaves the string open at end of document
        add_text("\"\\\"");
        emit_doc(1'b1, 1'b1);
        // nothing parsed before the end
        emit_doc(1'b1, 1'b1);
        // stray byte, then a word ignored after the error
        put_word(8'hFF, 1'b0, 1'b1);
        put_word(CH_RBRACK, 1'b0, 1'b0);
        // one level past the stack
        repeat (STACK_DEPTH + 1) doc_buf.push_back(CH_LBRACK);
        emit_doc(1'b1, 1'b1);

        // random documents, mostly well formed
        goal = byte_feed_q.size() + 800;
        while (byte_feed_q.size() < goal) begin
            sod_on = $urandom_range(0, 9) != 0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    add_value(0);
                    emit_doc(sod_on, 1'b1);
                end
                12, 13: begin
                    add_value(0);
                    doc_buf[$urandom_range(0, doc_buf.size() - 1)] = 8'($urandom_range(0, 255));
                    emit_doc(sod_on, 1'b1);
                end
                14, 15: begin
                    add_value(0);
                    cut = $urandom_range(0, doc_buf.size() - 1);
                    while (doc_buf.size() > cut) void'(doc_buf.pop_back());
                    emit_doc(sod_on, 1'b1);
                end
                16, 17: begin
                    add_nest();
                    emit_doc(sod_on, 1'b1);
                end
                default: begin
                    repeat ($urandom_range(1, 8))
                        put_word(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                                 $urandom_range(0, 5) == 0);
                end
            endcase
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed_q.size() != 0 || in_if.valid || token_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        $display("covered %0d documents in %0d byte words; %0d tokens checked",
                 docs_built, words_taken, tokens_seen);
        $display("tokens included %0d errors and %0d document ends; %0d mismatches",
                 error_tokens, end_tokens, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("timeout: %0d tokens still expected, %0d words unsent",
                 token_expect_q.size(), byte_feed_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/jst_pkg.sv
src/jst_if.sv
src/jst_stack_cell.sv
src/jst_ctx_stack.sv
src/jst_out_queue.sv
src/json_stream_tokenizer.sv
sim/tb_top.sv
